### sv/lpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg: shared constants for the hash table
// Opcodes, status codes, sizes and the Fibonacci multiplier.
// ----------------------------------------------------------------------------
package lpht_pkg;
	localparam int DEF_SLOTS      = 256;
	localparam int DEF_VALUE_BITS = 32;
	localparam int KEY_BITS       = 32;

	localparam logic [1:0] OP_FIND   = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_RESERVED = 2'd3;

	localparam logic [31:0] EMPTY_KEY = 32'hffff_ffff;
	// low 32 bits of 11400714819323198485 (only these matter mod 2^32)
	localparam logic [31:0] FIB_LO = 32'h7f4a_7c15;
endpackage

### sv/lpht_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

### sv/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table: open-addressing hash table, linear probing
// Fibonacci-hashed home slot, find / insert / remove / clear per transfer.
// ----------------------------------------------------------------------------
// One operation at a time. The input is ready only in idle with the result
// register empty, so a new transfer waits until the previous result has been
// taken. After reset, and after every clear, a sweep writes all SLOTS entries
// empty (no input accepted); the clear result is offered at once. Each probe
// of a slot is a memory read, then a compare, through the single port of the
// key/value memory; the hash (S_HASH) and the first read (S_HOME) come before
// the probes and the result register (S_DONE) after them. The insert write
// shares the last compare; a reserved key or a table already full goes
// straight to the result register. A remove then walks the later entries of
// the cluster, each one read, taken out, rehashed and re-inserted, and ends
// the walk at the empty slot that closes the cluster.
// ----------------------------------------------------------------------------
module linear_probe_hash_table
	import lpht_pkg::*;
#(
	parameter int SLOTS      = DEF_SLOTS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,        // slots_in_use
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,     // operation[1:0], key[33:2], value_in[65:34]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata      // status[1:0], value_out[33:2],
	                                      // slot_index[41:34], entry_count[50:42]
);
	localparam int AW = $clog2(SLOTS);
	localparam int CW = AW + 1;
	localparam int MW = KEY_BITS + VALUE_BITS;

	localparam logic [3:0] S_SWEEP  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_HASH   = 4'd2;   // fib product registered
	localparam logic [3:0] S_HOME   = 4'd3;   // home slot registered, issue read
	localparam logic [3:0] S_CMP    = 4'd4;   // read data valid
	localparam logic [3:0] S_RD     = 4'd5;   // issue read of probe_q
	localparam logic [3:0] S_DONE   = 4'd6;
	localparam logic [3:0] S_WALKRD = 4'd7;   // remove: read next cluster slot
	localparam logic [3:0] S_WALKCK = 4'd8;   // remove: check it
	localparam logic [3:0] S_REHOME = 4'd9;   // remove: re-insertion hash

	logic [3:0] state_q;
	logic [8:0] cfg_q;
	logic [CW-1:0] n_act;
	logic [1:0] op_q;
	logic [31:0] key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [31:0] fib_q;
	logic [AW-1:0] probe_q, hit_q, walk_q;
	logic [CW-1:0] dist_q, steps_q, count_q, lim_q;
	logic [AW-1:0] longest_q;
	logic reins_q;
	logic [1:0] st_q;
	logic [31:0] vout_q;
	logic [AW-1:0] slot_q;
	logic ovalid_q;

	logic we;
	logic [AW-1:0] addr;
	logic [MW-1:0] wdata, rdata;
	logic [31:0] rkey;
	logic [VALUE_BITS-1:0] rval;
	logic [CW+31:0] home_prod;
	logic [AW-1:0] home;
	logic [AW-1:0] probe_nx;

	lpht_ram #(.WIDTH(MW), .DEPTH(SLOTS)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	assign rkey = rdata[MW-1 -: KEY_BITS];
	assign rval = rdata[VALUE_BITS-1:0];

	always_comb begin
		if (cfg_q < 9'd4) n_act = CW'(4);
		else if (32'(cfg_q) > 32'(SLOTS)) n_act = CW'(SLOTS);
		else n_act = CW'(cfg_q);
	end

	assign home_prod = {{CW{1'b0}}, fib_q} * {32'd0, n_act};
	assign home      = home_prod[32 +: AW];
	assign probe_nx  = ({1'b0, probe_q} + 1'b1 >= n_act) ? '0 : probe_q + 1'b1;

	assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
	assign m_axis_tvalid = ovalid_q;
	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[1:0]   = st_q;
		m_axis_tdata[33:2]  = vout_q;
		m_axis_tdata[41:34] = 8'(slot_q);
		m_axis_tdata[50:42] = 9'(count_q);
	end

	// memory port
	always_comb begin
		we = 1'b0;
		addr = probe_q;
		wdata = {EMPTY_KEY, {VALUE_BITS{1'b0}}};
		case (state_q)
			S_SWEEP: begin
				we = 1'b1;
				addr = walk_q;
			end
			S_CMP: begin
				if ((op_q == OP_INSERT || reins_q) && rkey == EMPTY_KEY) begin
					we = 1'b1;
					wdata = {key_q, val_q};
				end else if (op_q == OP_REMOVE && !reins_q && rkey == key_q) begin
					we = 1'b1;
				end
			end
			S_WALKRD: addr = walk_q;
			S_WALKCK: begin
				addr = walk_q;
				we = (rkey != EMPTY_KEY);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			cfg_q <= 9'd256;
			walk_q <= '0;
			count_q <= '0;
			longest_q <= '0;
			ovalid_q <= 1'b0;
			reins_q <= 1'b0;
		end else begin
			if (cfg_we) cfg_q <= cfg_wdata;
			if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			unique case (state_q)
				S_SWEEP: begin
					walk_q <= walk_q + 1'b1;
					if (walk_q == AW'(SLOTS-1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						op_q <= s_axis_tdata[1:0];
						key_q <= s_axis_tdata[33:2];
						val_q <= VALUE_BITS'(s_axis_tdata[65:34]);
						fib_q <= s_axis_tdata[33:2] * FIB_LO;
						st_q <= ST_OK;
						vout_q <= '0;
						slot_q <= '0;
						reins_q <= 1'b0;
						if (s_axis_tdata[1:0] == OP_CLEAR) begin
							count_q <= '0;
							longest_q <= '0;
							walk_q <= '0;
							ovalid_q <= 1'b1;
							state_q <= S_SWEEP;
						end else if (s_axis_tdata[33:2] == EMPTY_KEY) begin
							st_q <= ST_RESERVED;
							state_q <= S_DONE;
						end else if (s_axis_tdata[1:0] == OP_INSERT && count_q >= n_act) begin
							st_q <= ST_FULL;
							state_q <= S_DONE;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					probe_q <= home;
					dist_q <= '0;
					if (op_q == OP_INSERT || reins_q) lim_q <= n_act;
					else if ({1'b0, longest_q} + 1'b1 > n_act) lim_q <= n_act;
					else lim_q <= {1'b0, longest_q} + 1'b1;
					state_q <= S_HOME;
				end
				S_HOME, S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (op_q == OP_INSERT || reins_q) begin
						if (rkey == EMPTY_KEY) begin
							count_q <= count_q + 1'b1;
							if ({1'b0, longest_q} < dist_q) longest_q <= AW'(dist_q);
							if (reins_q) begin
								walk_q <= (({1'b0, walk_q} + 1'b1) >= n_act) ? '0 : walk_q + 1'b1;
								steps_q <= steps_q + 1'b1;
								state_q <= S_WALKRD;
							end else begin
								slot_q <= probe_q;
								state_q <= S_DONE;
							end
						end else if (dist_q + 1'b1 >= lim_q) begin
							if (reins_q) begin
								walk_q <= (({1'b0, walk_q} + 1'b1) >= n_act) ? '0 : walk_q + 1'b1;
								steps_q <= steps_q + 1'b1;
								state_q <= S_WALKRD;
							end else begin
								st_q <= ST_FULL;
								state_q <= S_DONE;
							end
						end else begin
							probe_q <= probe_nx;
							dist_q <= dist_q + 1'b1;
							state_q <= S_RD;
						end
					end else if (rkey == key_q) begin
						slot_q <= probe_q;
						vout_q <= 32'(rval);
						if (op_q == OP_REMOVE) begin
							count_q <= count_q - 1'b1;
							hit_q <= probe_q;
							walk_q <= probe_nx;
							steps_q <= CW'(1);
							state_q <= S_WALKRD;
						end else begin
							state_q <= S_DONE;
						end
					end else if (dist_q + 1'b1 >= lim_q) begin
						st_q <= ST_NOTFOUND;
						state_q <= S_DONE;
					end else begin
						probe_q <= probe_nx;
						dist_q <= dist_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_WALKRD: begin
					if (steps_q >= n_act) begin
						reins_q <= 1'b0;
						if (count_q == '0) longest_q <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_WALKCK;
					end
				end
				S_WALKCK: begin
					if (rkey == EMPTY_KEY) begin
						reins_q <= 1'b0;
						if (count_q == '0) longest_q <= '0;
						state_q <= S_DONE;
					end else begin
						// taken out (written empty this cycle), now re-place
						count_q <= count_q - 1'b1;
						key_q <= rkey;
						val_q <= rval;
						fib_q <= rkey * FIB_LO;
						reins_q <= 1'b1;
						state_q <= S_REHOME;
					end
				end
				S_REHOME: state_q <= S_HASH;
				S_DONE: begin
					if (op_q == OP_REMOVE && st_q == ST_OK) slot_q <= hit_q;
					if (st_q != ST_OK) begin
						slot_q <= '0;
						vout_q <= '0;
					end
					if (op_q == OP_INSERT) vout_q <= '0;
					ovalid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### sv/lpht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_checker: port-level checks for the hash table
// Watches handshakes and result fields.
// ----------------------------------------------------------------------------
module lpht_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata
);
	import lpht_pkg::*;

	// a result never waits while a new input is taken
	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// failed operations report slot zero
	a_fail_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[41:34] == 8'd0)
		else $error("nonzero slot on failure");

	a_fail_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[33:2] == 32'd0)
		else $error("nonzero value on failure");
endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for linear_probe_hash_table
// Starts with a table of directed operations, then runs random
// find/insert/remove/clear traffic over several slot counts. A local model of
// the table predicts the responses, directed rows may fix their own, and
// every response transfer is checked field by field, in order, against them.
// ----------------------------------------------------------------------------
module tb;
	import lpht_pkg::*;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value;
		logic [7:0]  slot;
		logic [8:0]  count;
	} hash_resp_t;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] key;
		logic [31:0] val;
		bit          typed;
		hash_resp_t  resp;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [8:0]  cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;

	always #1 clk = ~clk;

	linear_probe_hash_table uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
	);

	// ---------------- table model ----------------
	logic [31:0] tbl_key [DEF_SLOTS];
	logic [31:0] tbl_val [DEF_SLOTS];
	int          tbl_count;
	int          tbl_longest;
	logic [8:0]  tbl_slots_cfg;
	hash_resp_t  pending_resp [$];
	int          errors = 0;

	function automatic int active_n();
		if (tbl_slots_cfg < 4) return 4;
		if (tbl_slots_cfg > DEF_SLOTS) return DEF_SLOTS;
		return tbl_slots_cfg;
	endfunction

	function automatic int home_of(logic [31:0] k, int n);
		logic [31:0] fib;
		logic [63:0] prod;
		fib  = k * FIB_LO;
		prod = {32'd0, fib} * 64'(n);
		return int'(prod >> 32);
	endfunction

	function automatic int step_of(int idx, int n);
		return (idx + 1 >= n) ? 0 : idx + 1;
	endfunction

	function automatic void wipe_table();
		for (int i = 0; i < DEF_SLOTS; i++) begin
			tbl_key[i] = EMPTY_KEY;
			tbl_val[i] = '0;
		end
		tbl_count   = 0;
		tbl_longest = 0;
	endfunction

	function automatic bit place_entry(logic [31:0] k, logic [31:0] v, int n, output int slot);
		int idx;
		idx  = home_of(k, n);
		slot = 0;
		for (int d = 0; d < n; d++) begin
			if (tbl_key[idx] == EMPTY_KEY) begin
				tbl_key[idx] = k;
				tbl_val[idx] = v;
				tbl_count++;
				if (tbl_longest < d) tbl_longest = d;
				slot = idx;
				return 1;
			end
			idx = step_of(idx, n);
		end
		return 0;
	endfunction

	// find and remove are bounded by the longest probe distance since the table was last empty
	function automatic bit locate_key(logic [31:0] k, int n, output int slot);
		int idx, lim;
		idx  = home_of(k, n);
		lim  = (tbl_longest + 1 > n) ? n : tbl_longest + 1;
		slot = 0;
		for (int d = 0; d < lim; d++) begin
			if (tbl_key[idx] == k) begin
				slot = idx;
				return 1;
			end
			idx = step_of(idx, n);
		end
		return 0;
	endfunction

	function automatic hash_resp_t apply_op(logic [1:0] op, logic [31:0] k, logic [31:0] v);
		hash_resp_t r;
		int n, slot, idx, dummy;
		logic [31:0] mk, mv;
		n = active_n();
		r = '0;
		slot = 0;
		if (op == OP_CLEAR) begin
			wipe_table();
		end else if (k == EMPTY_KEY) begin
			r.status = ST_RESERVED;
		end else if (op == OP_FIND) begin
			if (locate_key(k, n, slot)) r.value = tbl_val[slot];
			else begin
				r.status = ST_NOTFOUND;
				slot = 0;
			end
		end else if (op == OP_INSERT) begin
			if (tbl_count >= n || !place_entry(k, v, n, slot)) begin
				r.status = ST_FULL;
				slot = 0;
			end
		end else begin
			if (locate_key(k, n, slot)) begin
				r.value = tbl_val[slot];
				tbl_key[slot] = EMPTY_KEY;
				tbl_val[slot] = '0;
				tbl_count--;
				// pull out and re-home the rest of the cluster
				idx = step_of(slot, n);
				for (int s = 1; s < n && tbl_key[idx] != EMPTY_KEY; s++) begin
					mk = tbl_key[idx];
					mv = tbl_val[idx];
					tbl_key[idx] = EMPTY_KEY;
					tbl_val[idx] = '0;
					tbl_count--;
					void'(place_entry(mk, mv, n, dummy));
					idx = step_of(idx, n);
				end
				if (tbl_count == 0) tbl_longest = 0;
			end else begin
				r.status = ST_NOTFOUND;
				slot = 0;
			end
		end
		r.slot  = slot[7:0];
		r.count = tbl_count[8:0];
		return r;
	endfunction

	// ---------------- receiver ----------------
	bit rx_gaps = 1;
	bit rx_hold = 0;

	// long receiver hold-off, counted here while the sender keeps going
	initial forever begin
		wait (rx_hold);
		repeat (400) @(negedge clk);
		rx_hold = 0;
	end

	initial begin
		hash_resp_t got, want;
		int gap;
		forever begin
			gap = rx_gaps ? $urandom_range(0, 19) : 0;
			if (gap > 0) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			if (rx_hold) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
				while (rx_hold) @(negedge clk);
			end
			@(negedge clk);
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			got.status = m_axis_tdata[1:0];
			got.value  = m_axis_tdata[33:2];
			got.slot   = m_axis_tdata[41:34];
			got.count  = m_axis_tdata[50:42];
			if (pending_resp.size() == 0) begin
				$error("response transfer with nothing outstanding: %h", m_axis_tdata);
				errors++;
			end else begin
				want = pending_resp.pop_front();
				if (got.status !== want.status) begin
					$error("status: exp %0d got %0d", want.status, got.status);
					errors++;
				end
				if (got.value !== want.value) begin
					$error("value_out: exp %h got %h", want.value, got.value);
					errors++;
				end
				if (got.slot !== want.slot) begin
					$error("slot_index: exp %0d got %0d", want.slot, got.slot);
					errors++;
				end
				if (got.count !== want.count) begin
					$error("entry_count: exp %0d got %0d", want.count, got.count);
					errors++;
				end
			end
		end
	end

	// ---------------- sender ----------------
	bit tx_gaps = 1;
	logic [31:0] live_keys [$];

	task automatic send_op(logic [1:0] op, logic [31:0] k, logic [31:0] v,
	                       bit typed = 0, hash_resp_t typed_resp = '0);
		int gap;
		hash_resp_t r;
		gap = tx_gaps ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, v, k, op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		r = apply_op(op, k, v);
		pending_resp.push_back(typed ? typed_resp : r);
		if (op == OP_INSERT && r.status == ST_OK) live_keys.push_back(k);
		if (op == OP_CLEAR) live_keys.delete();
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (pending_resp.size() == 0);
		// a clear may still be sweeping the store after its response
		repeat (300) @(negedge clk);
	endtask

	task automatic set_slots(logic [8:0] n);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= n;
		tbl_slots_cfg = n;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_key();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 2) return EMPTY_KEY;
		if (sel < 70 && live_keys.size() > 0)
			return live_keys[$urandom_range(0, live_keys.size() - 1)];
		if (sel < 85) return $urandom_range(0, 63);
		return $urandom;
	endfunction

	task automatic random_ops(int count, bit with_hold);
		int sel, n;
		logic [1:0] op;
		n = active_n();
		for (int i = 0; i < count; i++) begin
			if (with_hold && i == 20) rx_hold = 1;
			// sender pause until every response is back
			if ($urandom_range(0, 59) == 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				wait (pending_resp.size() == 0);
			end
			sel = $urandom_range(0, 99);
			if (sel < 2) op = OP_CLEAR;
			else if (sel < 32) op = OP_FIND;
			else if (sel < 72 && tbl_count < (n * 3) / 4 + 2) op = OP_INSERT;
			else op = OP_REMOVE;
			send_op(op, pick_key(), $urandom);
		end
	endtask

	// ---------------- main sequence ----------------
	stim_row_t directed [$];

	function automatic stim_row_t row(logic [1:0] op, logic [31:0] k, logic [31:0] v,
	                                  bit typed = 0, logic [1:0] st = ST_OK,
	                                  logic [31:0] val = 0, logic [7:0] sl = 0,
	                                  logic [8:0] cnt = 0);
		stim_row_t r;
		r.op = op; r.key = k; r.val = v; r.typed = typed;
		r.resp.status = st; r.resp.value = val; r.resp.slot = sl; r.resp.count = cnt;
		return r;
	endfunction

	initial begin
		logic [8:0] slot_plan [] = '{9'd4, 9'd0, 9'd17, 9'd511, 9'd3, 9'd64, 9'd8, 9'd256};
		tbl_slots_cfg = 9'd256;
		wipe_table();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, reserved key, extremes, duplicates, clear
		directed.push_back(row(OP_FIND, 32'd0, 0, 1, ST_NOTFOUND));
		directed.push_back(row(OP_REMOVE, 32'd5, 0, 1, ST_NOTFOUND));
		directed.push_back(row(OP_INSERT, EMPTY_KEY, 32'h1, 1, ST_RESERVED));
		directed.push_back(row(OP_FIND, EMPTY_KEY, 0, 1, ST_RESERVED));
		directed.push_back(row(OP_REMOVE, EMPTY_KEY, 0, 1, ST_RESERVED));
		directed.push_back(row(OP_INSERT, 32'd0, 32'hffff_ffff, 1, ST_OK, 0, 0, 1));
		directed.push_back(row(OP_FIND, 32'd0, 0, 1, ST_OK, 32'hffff_ffff, 0, 1));
		directed.push_back(row(OP_INSERT, 32'hffff_fffe, 32'h0, 0));
		directed.push_back(row(OP_INSERT, 32'h8000_0000, 32'h5555_aaaa, 0));
		directed.push_back(row(OP_INSERT, 32'h0000_0001, 32'haaaa_5555, 0));
		directed.push_back(row(OP_INSERT, 32'd0, 32'h1234_5678, 0));
		directed.push_back(row(OP_FIND, 32'hffff_fffe, 0, 0));
		directed.push_back(row(OP_REMOVE, 32'd0, 0, 0));
		directed.push_back(row(OP_FIND, 32'd0, 0, 0));
		directed.push_back(row(OP_REMOVE, 32'h8000_0000, 0, 0));
		directed.push_back(row(OP_REMOVE, 32'h8000_0000, 0, 0));
		directed.push_back(row(OP_CLEAR, 32'h0, 0, 1, ST_OK, 0, 0, 0));
		directed.push_back(row(OP_FIND, 32'hffff_fffe, 0, 1, ST_NOTFOUND));
		foreach (directed[i])
			send_op(directed[i].op, directed[i].key, directed[i].val,
			        directed[i].typed, directed[i].resp);

		// tiny table filled past capacity
		set_slots(9'd4);
		send_op(OP_CLEAR, 0, 0);
		for (int i = 0; i < 6; i++) send_op(OP_INSERT, 32'(i * 7), $urandom);
		send_op(OP_REMOVE, 32'd7, 0);
		send_op(OP_FIND, 32'd14, 0);

		// default size, with the long receiver hold-off
		set_slots(9'd256);
		send_op(OP_CLEAR, 0, 0);
		random_ops(200, 1);

		foreach (slot_plan[p]) begin
			tx_gaps = (p % 3 != 1);
			rx_gaps = (p % 4 != 2);
			set_slots(slot_plan[p]);
			send_op(OP_CLEAR, 0, 0);
			random_ops(180, 0);
		end

		// shrink without a clear: entries above the new size stay counted
		set_slots(9'd64);
		send_op(OP_CLEAR, 0, 0);
		for (int i = 0; i < 20; i++) send_op(OP_INSERT, $urandom, $urandom);
		set_slots(9'd16);
		random_ops(60, 0);
		set_slots(9'd40);
		random_ops(40, 0);

		drain();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
